// ----- rtl/cpg_pkg.sv -----
// cpg_pkg: shared types, constants and the sine series for the circular path generator
// depends on nothing; imported by cpg_coord, circular_path_generator and the testbench

package cpg_pkg;

   // coordinate and tag widths, fixed by the register and field layout
   localparam int MM_W  = 32;
   localparam int TAG_W = 32;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_RADIUS   = 2'd2,
      CSR_STEP     = 2'd3
   } csr_index_type;

   // fixed-point constants for the series, q30
   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
   localparam logic [63:0] Q30_ROUND   = 64'd1 << 29;

   // magnitude of the first-quadrant sine entry r, quarter turn = 2^(addr_bits-2) entries,
   // scaled to 2^(sine_bits-1)-1 and rounded half up; evaluated at elaboration only
   function automatic logic [63:0] sine_mag(input int unsigned r,
                                            input int unsigned addr_bits,
                                            input int unsigned sine_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] m;
      logic [63:0] amp;
      logic [63:0] val;
      x   = (64'(r) * Q30_HALF_PI) >> (addr_bits - 2);
      x2  = (x * x) >> 30;
      // nested taylor terms, innermost first
      t   = Q30_ONE;
      t   = Q30_ONE - (((x2 * t) >> 30) / 64'd156);
      t   = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
      t   = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
      t   = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
      t   = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
      t   = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
      m   = (x * t) >> 30;
      amp = (64'd1 << (sine_bits - 1)) - 64'd1;
      val = (m * amp + Q30_ROUND) >> 30;
      if (val > amp) begin
         val = amp;
      end
      return val;
   endfunction

endpackage

// ----- rtl/circular_path_generator.sv -----
// circular_path_generator: steps a point around a circle on every tick beat
// depends on cpg_pkg and cpg_coord
//
//   channel | dir | handshake           | payload
//   req     | in  | req_valid/req_ready | req_track_tag
//   rsp     | out | rsp_valid/rsp_ready | rsp_pos_x, rsp_pos_y, rsp_tag_out, rsp_pos_valid
//   csr     | in  | csr_valid/csr_ready | csr_index, csr_data
//
// one tick beat accepted per cycle while req_ready is high; the edge that takes a tick loads
// the stage register (sine table read), and the result register rsp is loaded (multiply, round
// and clamp) from the stage register once rsp is free, so a stall in rsp holds the staged tick
// csr writes are always taken and restart the angle at zero
// rsp stalls back up through the stage register; req_ready drops only when both are full

module circular_path_generator import cpg_pkg::*; #(
   parameter int PHASE_BITS     = 32,
   parameter int SINE_ADDR_BITS = 10,
   parameter int SINE_BITS      = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   // tick beats
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [TAG_W-1:0]        req_track_tag,
   // position beats
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [MM_W-1:0]  rsp_pos_x,
   output logic signed [MM_W-1:0]  rsp_pos_y,
   output logic [TAG_W-1:0]        rsp_tag_out,
   output logic                    rsp_pos_valid,
   // register writes
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [MM_W-1:0]         csr_data
);

   localparam int QUARTER = 1 << (SINE_ADDR_BITS - 2);
   localparam logic [SINE_ADDR_BITS-1:0] QUARTER_A = SINE_ADDR_BITS'(QUARTER);
   localparam logic [SINE_ADDR_BITS-2:0] QUARTER_R = (SINE_ADDR_BITS - 1)'(QUARTER);

   // first-quadrant sine table, one entry past the quarter turn
   typedef logic signed [SINE_BITS-1:0] trig_tab_type [QUARTER+1];

   function automatic trig_tab_type build_trig_tab();
      trig_tab_type tab;
      for (int k = 0; k <= QUARTER; k++) begin
         tab[k] = SINE_BITS'(sine_mag(k, SINE_ADDR_BITS, SINE_BITS));
      end
      return tab;
   endfunction

   localparam trig_tab_type TRIG_TAB = build_trig_tab();

   // full-turn sine from the quarter table by folding and sign
   function automatic logic signed [SINE_BITS-1:0] trig_at(input logic [SINE_ADDR_BITS-1:0] idx);
      logic [SINE_ADDR_BITS-2:0]   r;
      logic signed [SINE_BITS-1:0] mag;
      r = {1'b0, idx[SINE_ADDR_BITS-3:0]};
      if (idx[SINE_ADDR_BITS-2]) begin
         r = QUARTER_R - r;
      end
      mag = TRIG_TAB[r];
      return idx[SINE_ADDR_BITS-1] ? -mag : mag;
   endfunction

   // configuration
   logic signed [MM_W-1:0] center_x_ff, center_x_in;
   logic signed [MM_W-1:0] center_y_ff, center_y_in;
   logic signed [MM_W-1:0] radius_ff, radius_in;
   logic signed [MM_W-1:0] step_ff, step_in;
   // angle of the next tick
   logic [PHASE_BITS-1:0]  phase_ff, phase_in;
   // stage register: looked-up trig values
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_ok_ff, s1_ok_in;
   logic [TAG_W-1:0]            s1_tag_ff, s1_tag_in;
   logic signed [SINE_BITS-1:0] s1_sin_ff, s1_sin_in;
   logic signed [SINE_BITS-1:0] s1_cos_ff, s1_cos_in;
   // result register, also the last computed position
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff, rsp_ok_in;
   logic [TAG_W-1:0]       rsp_tag_ff, rsp_tag_in;
   logic signed [MM_W-1:0] rsp_pos_x_ff, rsp_pos_x_in;
   logic signed [MM_W-1:0] rsp_pos_y_ff, rsp_pos_y_in;

   logic                      csr_accept;
   logic                      req_accept;
   logic                      rsp_free;
   logic                      s1_move;
   logic                      cfg_ok;
   logic [PHASE_BITS-1:0]     step_scaled;
   logic [SINE_ADDR_BITS-1:0] sin_idx;
   logic [SINE_ADDR_BITS-1:0] cos_idx;
   logic signed [MM_W-1:0]    new_x;
   logic signed [MM_W-1:0]    new_y;

   // handshakes and flow through the two registers
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign s1_move    = s1_valid_ff && rsp_free;
   assign req_ready  = !s1_valid_ff || rsp_free;
   assign req_accept = req_valid && req_ready;

   // settings enable output only for a non-negative radius and a nonzero step
   assign cfg_ok = !radius_ff[MM_W-1] && (step_ff != '0);

   // step in phase units
   if (PHASE_BITS >= MM_W) begin : g_step_wide
      assign step_scaled = PHASE_BITS'(step_ff) << (PHASE_BITS - MM_W);
   end else begin : g_step_narrow
      assign step_scaled = step_ff[MM_W-1 -: PHASE_BITS];
   end

   // table addresses for this tick's angle
   assign sin_idx = phase_ff[PHASE_BITS-1 -: SINE_ADDR_BITS];
   assign cos_idx = sin_idx + QUARTER_A;

   // register writes and angle update
   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      radius_in   = radius_ff;
      step_in     = step_ff;
      phase_in    = phase_ff;
      if (csr_accept) begin
         phase_in = '0;
         case (csr_index_type'(csr_index))
            CSR_CENTER_X: center_x_in = csr_data;
            CSR_CENTER_Y: center_y_in = csr_data;
            CSR_RADIUS:   radius_in   = csr_data;
            CSR_STEP:     step_in     = csr_data;
            default:      phase_in    = '0;
         endcase
      end else if (req_accept && cfg_ok) begin
         phase_in = phase_ff + step_scaled;
      end
   end

   // stage register load
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_ok_in    = s1_ok_ff;
      s1_tag_in   = s1_tag_ff;
      s1_sin_in   = s1_sin_ff;
      s1_cos_in   = s1_cos_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_ok_in    = cfg_ok;
         s1_tag_in   = req_track_tag;
         s1_sin_in   = trig_at(sin_idx);
         s1_cos_in   = trig_at(cos_idx);
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   // coordinates
   cpg_coord #(
      .SINE_BITS (SINE_BITS)
   ) u_coord_x (
      .center (center_x_ff),
      .radius (radius_ff),
      .trig   (s1_cos_ff),
      .pos    (new_x)
   );

   cpg_coord #(
      .SINE_BITS (SINE_BITS)
   ) u_coord_y (
      .center (center_y_ff),
      .radius (radius_ff),
      .trig   (s1_sin_ff),
      .pos    (new_y)
   );

   // result register; disabled ticks repeat the last position
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_pos_x_in = rsp_pos_x_ff;
      rsp_pos_y_in = rsp_pos_y_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = s1_ok_ff;
         rsp_tag_in   = s1_tag_ff;
         if (s1_ok_ff) begin
            rsp_pos_x_in = new_x;
            rsp_pos_y_in = new_y;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff  <= '0;
         center_y_ff  <= '0;
         radius_ff    <= -MM_W'(65536);
         step_ff      <= '0;
         phase_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_pos_x_ff <= '0;
         rsp_pos_y_ff <= '0;
      end else begin
         center_x_ff  <= center_x_in;
         center_y_ff  <= center_y_in;
         radius_ff    <= radius_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_pos_x_ff <= rsp_pos_x_in;
         rsp_pos_y_ff <= rsp_pos_y_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_ok_ff   <= s1_ok_in;
      s1_tag_ff  <= s1_tag_in;
      s1_sin_ff  <= s1_sin_in;
      s1_cos_ff  <= s1_cos_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_tag_ff <= rsp_tag_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pos_x     = rsp_pos_x_ff;
   assign rsp_pos_y     = rsp_pos_y_ff;
   assign rsp_tag_out   = rsp_tag_ff;
   assign rsp_pos_valid = rsp_ok_ff;

   // a register write restarts the angle
   a_csr_clears_phase: assert property (@(posedge clock) disable iff (reset)
      csr_accept |=> (phase_ff == '0))
      else $error("phase not cleared after register write");

   // disabled settings never move the angle
   a_disabled_phase_holds: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !cfg_ok && !csr_accept) |=> $stable(phase_ff))
      else $error("phase moved while settings disabled");

   // a disabled tick repeats the previous position
   a_disabled_pos_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_move && !s1_ok_ff) |=> ($stable(rsp_pos_x_ff) && $stable(rsp_pos_y_ff)))
      else $error("position changed on disabled tick");

   // a staged tick is kept until the result register takes it
   a_stage_not_lost: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_free) |=> s1_valid_ff)
      else $error("staged tick dropped under stall");

   // a result held under stall is not overwritten
   a_rsp_not_lost: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_tag_ff)))
      else $error("result overwritten under stall");

endmodule

// ----- rtl/cpg_coord.sv -----
// cpg_coord: one coordinate of the circle, centre + round(radius * trig), saturated
// depends on cpg_pkg (coordinate width)

module cpg_coord import cpg_pkg::*; #(
   parameter int SINE_BITS = 16
) (
   input  logic signed [MM_W-1:0]      center,
   input  logic signed [MM_W-1:0]      radius,
   input  logic signed [SINE_BITS-1:0] trig,
   output logic signed [MM_W-1:0]      pos
);

   localparam int PROD_W = MM_W + SINE_BITS;
   localparam int OFF_W  = PROD_W - (SINE_BITS - 1);
   localparam int SUM_W  = OFF_W + 1;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (SINE_BITS - 2);
   localparam logic signed [MM_W-1:0]   POS_MAX = {1'b0, {(MM_W-1){1'b1}}};
   localparam logic signed [MM_W-1:0]   POS_MIN = {1'b1, {(MM_W-1){1'b0}}};

   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] prod_rnd;
   logic signed [OFF_W-1:0]  offset;
   logic signed [SUM_W-1:0]  sum;

   // scaled offset, rounded half up and floored back to the position grid
   assign prod     = PROD_W'(radius) * PROD_W'(trig);
   assign prod_rnd = prod + ROUND_HALF;
   assign offset   = prod_rnd[PROD_W-1:SINE_BITS-1];

   // add centre and clamp to the signed coordinate range
   assign sum = SUM_W'(center) + SUM_W'(offset);

   always_comb begin
      if (sum > SUM_W'(POS_MAX)) begin
         pos = POS_MAX;
      end else if (sum < SUM_W'(POS_MIN)) begin
         pos = POS_MIN;
      end else begin
         pos = sum[MM_W-1:0];
      end
   end

endmodule

// ----- tb/testbench.sv -----
// testbench for circular_path_generator: directed table, then randomized tick traffic
// depends on cpg_pkg and the circular_path_generator rtl; self-checking, no external files
`timescale 1ns / 100ps

module testbench import cpg_pkg::*;;

   localparam int PHASE_W       = 32;
   localparam int LUT_ADDR_BITS = 10;
   localparam int LUT_BITS      = 16;
   localparam int LUT_SIZE      = 1 << LUT_ADDR_BITS;
   localparam int QUARTER       = 1 << (LUT_ADDR_BITS - 2);
   localparam int SETTLE_CYCLES = 3;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_TICKS   = 430;

   localparam longint unsigned Q30      = 64'd1 << 30;
   localparam longint unsigned HALF_PI  = 64'd1686629713;
   localparam longint unsigned LUT_AMP  = (64'd1 << (LUT_BITS - 1)) - 64'd1;
   // divisors of the nested sine series, innermost first
   localparam logic [47:0] SERIES_DIV = {8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

   typedef enum logic [1:0] {
      ROW_CSR,
      ROW_TICK,
      ROW_TICK_FIXED
   } row_kind_type;

   typedef struct packed {
      logic signed [MM_W-1:0] x;
      logic signed [MM_W-1:0] y;
      logic [TAG_W-1:0]       tag;
      logic                   ok;
   } position_type;

   typedef struct packed {
      row_kind_type  kind;
      csr_index_type idx;
      logic [31:0]   data;
      logic [31:0]   want_x;
      logic [31:0]   want_y;
      logic          want_ok;
   } stim_row_type;

   localparam int DIR_ROWS = 30;

   // directed sequence; fixed rows carry the position that must come back
   stim_row_type directed_rows [DIR_ROWS] = '{
      '{ROW_TICK_FIXED, CSR_CENTER_X, 32'h00000000, 32'h00000000, 32'h00000000, 1'b0},
      '{ROW_TICK_FIXED, CSR_CENTER_X, 32'hFFFFFFFF, 32'h00000000, 32'h00000000, 1'b0},
      '{ROW_CSR,        CSR_RADIUS,   32'h00000000, 32'h0,        32'h0,        1'b0},
      '{ROW_TICK_FIXED, CSR_CENTER_X, 32'h00000001, 32'h00000000, 32'h00000000, 1'b0},
      '{ROW_CSR,        CSR_CENTER_X, 32'h7FFFFFFF, 32'h0,        32'h0,        1'b0},
      '{ROW_CSR,        CSR_CENTER_Y, 32'h80000000, 32'h0,        32'h0,        1'b0},
      '{ROW_CSR,        CSR_STEP,     32'h00000001, 32'h0,        32'h0,        1'b0},
      '{ROW_TICK_FIXED, CSR_CENTER_X, 32'hA5A5A5A5, 32'h7FFFFFFF, 32'h80000000, 1'b1},
      '{ROW_CSR,        CSR_RADIUS,   32'h7FFFFFFF, 32'h0,        32'h0,        1'b0},
      '{ROW_TICK_FIXED, CSR_CENTER_X, 32'h5A5A5A5A, 32'h7FFFFFFF, 32'h80000000, 1'b1},
      '{ROW_CSR,        CSR_STEP,     32'h40000000, 32'h0,        32'h0,        1'b0},
      '{ROW_TICK,       CSR_CENTER_X, 32'h00000010, 32'h0,        32'h0,        1'b0},
      '{ROW_TICK,       CSR_CENTER_X, 32'h00000020, 32'h0,        32'h0,        1'b0},
      '{ROW_TICK,       CSR_CENTER_X, 32'h00000040, 32'h0,        32'h0,        1'b0},
      '{ROW_TICK,       CSR_CENTER_X, 32'h00000080, 32'h0,        32'h0,        1'b0},
      '{ROW_CSR,        CSR_CENTER_X, 32'h80000000, 32'h0,        32'h0,        1'b0},
      '{ROW_CSR,        CSR_STEP,     32'h80000000, 32'h0,        32'h0,        1'b0},
      '{ROW_TICK,       CSR_CENTER_X, 32'h12345678, 32'h0,        32'h0,        1'b0},
      '{ROW_TICK,       CSR_CENTER_X, 32'h87654321, 32'h0,        32'h0,        1'b0},
      '{ROW_CSR,        CSR_RADIUS,   32'hFFFFFFFF, 32'h0,        32'h0,        1'b0},
      '{ROW_TICK,       CSR_CENTER_X, 32'h0000FFFF, 32'h0,        32'h0,        1'b0},
      '{ROW_CSR,        CSR_RADIUS,   32'h00100000, 32'h0,        32'h0,        1'b0},
      '{ROW_CSR,        CSR_STEP,     32'h00000000, 32'h0,        32'h0,        1'b0},
      '{ROW_TICK,       CSR_CENTER_X, 32'hFFFF0000, 32'h0,        32'h0,        1'b0},
      '{ROW_CSR,        CSR_STEP,     32'hFFC00000, 32'h0,        32'h0,        1'b0},
      '{ROW_TICK,       CSR_CENTER_X, 32'h3C3C3C3C, 32'h0,        32'h0,        1'b0},
      '{ROW_TICK,       CSR_CENTER_X, 32'hC3C3C3C3, 32'h0,        32'h0,        1'b0},
      '{ROW_TICK,       CSR_CENTER_X, 32'h0F0F0F0F, 32'h0,        32'h0,        1'b0},
      '{ROW_CSR,        CSR_CENTER_Y, 32'h00000000, 32'h0,        32'h0,        1'b0},
      '{ROW_TICK,       CSR_CENTER_X, 32'hF0F0F0F0, 32'h0,        32'h0,        1'b0}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [TAG_W-1:0]       req_track_tag = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic signed [MM_W-1:0] rsp_pos_x;
   logic signed [MM_W-1:0] rsp_pos_y;
   logic [TAG_W-1:0]       rsp_tag_out;
   logic                   rsp_pos_valid;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   csr_index_type          csr_index = CSR_CENTER_X;
   logic [MM_W-1:0]        csr_data = '0;

   // shadow of the circle settings and the point
   logic signed [31:0] cx_reg;
   logic signed [31:0] cy_reg;
   logic signed [31:0] radius_reg;
   logic signed [31:0] step_reg;
   logic [PHASE_W-1:0] angle_acc;
   logic signed [31:0] held_x;
   logic signed [31:0] held_y;
   int                 sine_lut [LUT_SIZE];

   position_type pending_pos [$];
   int           failures = 0;
   int           cycle_count = 0;
   int           req_idle_pct;
   int           rsp_stall_pct;

   circular_path_generator #(
      .PHASE_BITS     (PHASE_W),
      .SINE_ADDR_BITS (LUT_ADDR_BITS),
      .SINE_BITS      (LUT_BITS)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_track_tag (req_track_tag),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_tag_out   (rsp_tag_out),
      .rsp_pos_valid (rsp_pos_valid),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #1 clock = ~clock;

   // signed sine table entry k, full turn over LUT_SIZE entries
   function automatic int lut_entry(input int unsigned k);
      longint unsigned q;
      longint unsigned r;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned m;
      longint unsigned val;
      int              i;
      q = k >> (LUT_ADDR_BITS - 2);
      r = k & (QUARTER - 1);
      if (q[0]) begin
         r = QUARTER - r;
      end
      x  = (r * HALF_PI) >> (LUT_ADDR_BITS - 2);
      x2 = (x * x) >> 30;
      t  = Q30;
      for (i = 0; i < 6; i++) begin
         t = Q30 - (((x2 * t) >> 30) / SERIES_DIV[8*(5-i) +: 8]);
      end
      m   = (x * t) >> 30;
      val = (m * LUT_AMP + (64'd1 << 29)) >> 30;
      if (val > LUT_AMP) begin
         val = LUT_AMP;
      end
      return (q >= 2) ? -int'(val) : int'(val);
   endfunction

   // centre plus rounded radius * trig, clamped to 32 bits
   function automatic logic [31:0] place(input logic signed [31:0] centre, input int trig);
      longint off;
      longint s;
      off = (longint'(radius_reg) * trig + (longint'(1) << (LUT_BITS - 2))) >>> (LUT_BITS - 1);
      s   = longint'(centre) + off;
      if (s > 64'sd2147483647) begin
         s = 64'sd2147483647;
      end
      if (s < -64'sd2147483648) begin
         s = -64'sd2147483648;
      end
      return s[31:0];
   endfunction

   // position produced by one tick, advancing the shadow point
   function automatic position_type next_position(input logic [TAG_W-1:0] tag);
      position_type             p;
      logic [LUT_ADDR_BITS-1:0] sin_addr;
      logic [LUT_ADDR_BITS-1:0] cos_addr;
      p.tag = tag;
      p.ok  = (radius_reg >= 0) && (step_reg != 0);
      if (p.ok) begin
         sin_addr  = angle_acc[PHASE_W-1 -: LUT_ADDR_BITS];
         cos_addr  = sin_addr + LUT_ADDR_BITS'(QUARTER);
         held_x    = place(cx_reg, sine_lut[cos_addr]);
         held_y    = place(cy_reg, sine_lut[sin_addr]);
         angle_acc = angle_acc + step_reg;
      end
      p.x = held_x;
      p.y = held_y;
      return p;
   endfunction

   function automatic void apply_register(input csr_index_type idx, input logic [31:0] value);
      case (idx)
         CSR_CENTER_X: begin
            cx_reg = value;
         end
         CSR_CENTER_Y: begin
            cy_reg = value;
         end
         CSR_RADIUS: begin
            radius_reg = value;
         end
         CSR_STEP: begin
            step_reg = value;
         end
         default: begin
         end
      endcase
      angle_acc = '0;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
         failures++;
      end
   endfunction

   // one tick beat; fixed rows replace the predicted position
   task automatic send_tick(input logic [TAG_W-1:0] tag, input logic fixed,
                            input position_type fixed_pos);
      position_type p;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_track_tag <= tag;
      do @(posedge clock); while (!req_ready);
      p = next_position(tag);
      if (fixed) begin
         p = fixed_pos;
      end
      pending_pos.push_back(p);
      @(negedge clock);
   endtask

   // register write, only once every position has come back
   task automatic write_register(input csr_index_type idx, input logic [31:0] value);
      req_valid <= 1'b0;
      while (pending_pos.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // new random circle: each register with even odds, step always written if none was, extremes weighted in
   task automatic reprogram_circle();
      csr_index_type idx;
      logic [31:0]   value;
      int            sel;
      int            k;
      logic          wrote;
      wrote = 1'b0;
      for (k = 0; k < 4; k++) begin
         idx = csr_index_type'(k);
         sel = $urandom_range(99);
         if ($urandom_range(1) == 0 && !(idx == CSR_STEP && !wrote)) begin
            continue;
         end
         case (idx)
            CSR_RADIUS: begin
               if (sel < 10)      value = 32'h80000000 | $urandom();
               else if (sel < 15) value = 32'h7FFFFFFF;
               else if (sel < 20) value = 32'h00000000;
               else if (sel < 70) value = $urandom_range(0, 32'h04000000);
               else               value = $urandom() & 32'h7FFFFFFF;
            end
            CSR_STEP: begin
               if (sel < 8)       value = 32'h00000000;
               else if (sel < 12) value = 32'h80000000;
               else if (sel < 16) value = 32'h7FFFFFFF;
               else if (sel < 30) value = $urandom() & 32'hFFC00000;
               else if (sel < 40) value = $urandom_range(1, 64);
               else if (sel < 45) value = -$urandom_range(1, 64);
               else               value = $urandom();
            end
            default: begin
               if (sel < 10)      value = 32'h7FFFFFFF;
               else if (sel < 20) value = 32'h80000000;
               else if (sel < 60) value = $urandom_range(0, 32'h01FFFFFF) - 32'h01000000;
               else               value = $urandom();
            end
         endcase
         write_register(idx, value);
         wrote = 1'b1;
      end
   endtask

   // receiver stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // position beats against the oldest prediction
   always @(posedge clock) begin : position_check
      position_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pos.size() == 0) begin
            $display("%0t: position beat with no tick waiting, x %h y %h tag %h", $time,
                     rsp_pos_x, rsp_pos_y, rsp_tag_out);
            failures++;
         end else begin
            want = pending_pos.pop_front();
            check_field("pos_x", want.x, rsp_pos_x);
            check_field("pos_y", want.y, rsp_pos_y);
            check_field("tag_out", want.tag, rsp_tag_out);
            check_field("pos_valid", 32'(want.ok), 32'(rsp_pos_valid));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("circular_path_generator verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type row;
      position_type fixed_pos;
      int           k;
      int           ph;
      int           issued;
      int           n;
      int           j;

      for (k = 0; k < LUT_SIZE; k++) begin
         sine_lut[k] = lut_entry(k);
      end
      cx_reg     = '0;
      cy_reg     = '0;
      radius_reg = -32'sd65536;
      step_reg   = '0;
      angle_acc  = '0;
      held_x     = '0;
      held_y     = '0;
      req_idle_pct  = 8;
      rsp_stall_pct = 76;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      for (k = 0; k < DIR_ROWS; k++) begin
         row = directed_rows[k];
         if (row.kind == ROW_CSR) begin
            write_register(row.idx, row.data);
         end else begin
            fixed_pos = '{x: row.want_x, y: row.want_y, tag: row.data, ok: row.want_ok};
            send_tick(row.data, row.kind == ROW_TICK_FIXED, fixed_pos);
         end
      end

      // random traffic in three idling phases, circle reprogrammed between bursts
      for (ph = 0; ph < 3; ph++) begin
         req_idle_pct  = (ph == 0) ? 8 : (ph == 1) ? 76 : 0;
         rsp_stall_pct = (ph == 0) ? 76 : (ph == 1) ? 8 : 0;
         issued = 0;
         while (issued < PHASE_TICKS) begin
            reprogram_circle();
            n = $urandom_range(8, 60);
            for (j = 0; j < n; j++) begin
               send_tick($urandom(), 1'b0, '0);
            end
            issued += n;
         end
      end

      // drain
      req_valid <= 1'b0;
      while (pending_pos.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
      if (failures == 0) begin
         $display("circular_path_generator verification clean");
      end else begin
         $display("circular_path_generator verification failed");
      end
      $finish;
   end

endmodule
